@@ design/bfba_pkg.sv @@
// Package for the best-fit block allocator.
// Holds the sizing constants, status codes and the payload structs of both channels.
// Depends on nothing.
package bfba_pkg;

  localparam int NUM_BLOCKS  = 32;
  localparam int SIZE_BITS   = 16;
  localparam int IDX_BITS    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_BITS    = $clog2(NUM_BLOCKS + 1);
  localparam int LIMIT_BITS  = 17;
  localparam int LEFT_BITS   = (SIZE_BITS > LIMIT_BITS) ? SIZE_BITS : LIMIT_BITS;
  localparam int IN_SIZE_BITS  = 16;
  localparam int OUT_IDX_BITS  = 5;
  localparam int OUT_LEFT_BITS = 16;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(10000);

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  localparam logic [1:0] ST_LOADED    = 2'd0;
  localparam logic [1:0] ST_ALLOCATED = 2'd1;
  localparam logic [1:0] ST_NONE      = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic                    action;
    logic [IN_SIZE_BITS-1:0] size_value;
  } in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [OUT_IDX_BITS-1:0]  block_index;
    logic [OUT_LEFT_BITS-1:0] leftover;
  } out_t;

endpackage

@@ design/best_fit_block_allocator.sv @@
// Best-fit block allocator: top level with the block table memory and scan sequencer.
// Depends on bfba_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one item per transfer:
//   action 0 appends a block size to the next table slot, action 1 asks for
//   the best-fit unused block for a file size. Every item yields exactly one
//   result transfer on out_valid/out_stall/out_data.
//   cfg_wr_en/cfg_wr_data write the leftover limit; write it only while idle.
// Sequencing:
//   A load's result goes from res_r into the output register. A request
//   scans the table, which sits in one memory with a single read port, one
//   entry per cycle; each entry read is compared against the best fit so
//   far. Once the last read has drained, a write-back step marks the chosen
//   block used, and the result goes from res_r into the output register.
//   One item is in work at a time; in_stall is high until its result is
//   loaded, so the next item is not taken before then.
// Reset:
//   rst_n clears the block count, the output valid and sets the limit to
//   10000. The table itself needs no clearing: only slots below the count
//   are ever read, and a load writes its slot as unused.
// Stall:
//   A finished result sits in the output register; the next item is taken
//   meanwhile, and its result waits until the register frees up.
module best_fit_block_allocator
  import bfba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_wr_en,
  input  logic [LIMIT_BITS-1:0] cfg_wr_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WB   = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [SIZE_BITS:0] mem [NUM_BLOCKS];

  logic [1:0]            state_r, state_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic [CNT_BITS-1:0]   addr_r, addr_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [IDX_BITS-1:0]   rd_idx_r;
  logic [SIZE_BITS:0]    rd_data_r;
  logic [LIMIT_BITS-1:0] limit_r;
  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_data_r, out_data_nxt;
  out_t                  res_r, res_nxt;
  logic [SIZE_BITS-1:0]  req_r, req_nxt;
  logic [LEFT_BITS-1:0]  best_left_r, best_left_nxt;
  logic [IDX_BITS-1:0]   best_idx_r, best_idx_nxt;
  logic [SIZE_BITS-1:0]  best_size_r, best_size_nxt;
  logic                  found_r, found_nxt;

  logic                  in_xfer;
  logic                  out_free;
  logic [SIZE_BITS-1:0]  in_size;
  logic [SIZE_BITS-1:0]  ent_size;
  logic                  ent_used;
  logic [SIZE_BITS-1:0]  ent_left;
  logic                  ent_fit;
  logic                  mem_we;
  logic [IDX_BITS-1:0]   mem_waddr;
  logic [SIZE_BITS:0]    mem_wdata;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign in_size   = SIZE_BITS'(in_data.size_value);

  assign ent_size = rd_data_r[SIZE_BITS-1:0];
  assign ent_used = rd_data_r[SIZE_BITS];
  assign ent_left = ent_size - req_r;
  assign ent_fit  = !ent_used && (ent_size >= req_r) &&
                    (LEFT_BITS'(ent_left) < best_left_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    addr_nxt      = addr_r;
    rd_vld_nxt    = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    res_nxt       = res_r;
    req_nxt       = req_r;
    best_left_nxt = best_left_r;
    best_idx_nxt  = best_idx_r;
    best_size_nxt = best_size_r;
    found_nxt     = found_r;
    mem_we        = 1'b0;
    mem_waddr     = count_r[IDX_BITS-1:0];
    mem_wdata     = {1'b0, in_size};
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_data.action == ACT_LOAD) begin
            state_nxt = S_FIN;
            if (count_r == CNT_BITS'(NUM_BLOCKS)) begin
              res_nxt = '{status: ST_FULL, block_index: '0, leftover: '0};
            end else begin
              mem_we    = 1'b1;
              count_nxt = count_r + 1'b1;
              res_nxt   = '{status: ST_LOADED,
                            block_index: OUT_IDX_BITS'(count_r),
                            leftover: '0};
            end
          end else begin
            state_nxt     = S_SCAN;
            req_nxt       = in_size;
            addr_nxt      = '0;
            best_left_nxt = LEFT_BITS'(limit_r);
            best_idx_nxt  = '0;
            found_nxt     = 1'b0;
          end
        end
      end
      S_SCAN: begin
        if (addr_r != count_r) begin
          rd_vld_nxt = 1'b1;
          addr_nxt   = addr_r + 1'b1;
        end else if (!rd_vld_r) begin
          state_nxt = S_WB;
        end
        if (rd_vld_r && ent_fit) begin
          best_left_nxt = LEFT_BITS'(ent_left);
          best_idx_nxt  = rd_idx_r;
          best_size_nxt = ent_size;
          found_nxt     = 1'b1;
        end
      end
      S_WB: begin
        state_nxt = S_FIN;
        if (found_r) begin
          mem_we    = 1'b1;
          mem_waddr = best_idx_r;
          mem_wdata = {1'b1, best_size_r};
          res_nxt   = '{status: ST_ALLOCATED,
                        block_index: OUT_IDX_BITS'(best_idx_r),
                        leftover: OUT_LEFT_BITS'(best_left_r)};
        end else begin
          res_nxt = '{status: ST_NONE, block_index: '0, leftover: '0};
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[addr_r[IDX_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      limit_r     <= LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    rd_idx_r    <= addr_r[IDX_BITS-1:0];
    out_data_r  <= out_data_nxt;
    res_r       <= res_nxt;
    req_r       <= req_nxt;
    best_left_r <= best_left_nxt;
    best_idx_r  <= best_idx_nxt;
    best_size_r <= best_size_nxt;
    found_r     <= found_nxt;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(NUM_BLOCKS))
    else $error("block count beyond table depth");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("second item taken while one is in work");

  a_we_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_IDLE || state_r == S_WB))
    else $error("table written outside load or write-back");

  a_rd_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> state_r == S_SCAN)
    else $error("read data returned outside scan");

  a_left_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_ALLOCATED) |->
      (LEFT_BITS'(out_data_r.leftover) < LEFT_BITS'(limit_r)))
    else $error("allocation leftover not below limit");
`endif

endmodule
